FILE: sv/xrs_pkg.sv
// xrs_pkg: shared types and constants of the xorshift128 random source
// used by xorshift128_random_source_unit; depends on nothing else
`timescale 1ns / 1ps

package xrs_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_DRAW   = 1'b1;

   // seeding multiplier and the unit-interval divisor 2^32 - 1
   localparam logic [31:0] SEED_MULT   = 32'd1812433253;
   localparam logic [32:0] DIVISOR     = 33'h0_FFFF_FFFF;

   // xorshift128 shift amounts
   localparam int SHIFT_A = 11;
   localparam int SHIFT_B = 8;
   localparam int SHIFT_C = 19;
   localparam int SHIFT_SEED = 30;

   // word and significand sizes
   localparam int WORD_W     = 32;
   localparam int NUM_WORDS  = 4;
   localparam int SIG_W      = 53;
   localparam int SGL_W      = 24;
   localparam int CNT_W      = 6;
   localparam int EXP_W      = 6;

   // last step index of the seeding pass
   localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(NUM_WORDS - 1);

   localparam logic [7:0]        EXP_BIAS = 8'd127;
   localparam logic [WORD_W-1:0] FLT_ONE  = 32'h3F80_0000;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_SEED  = 7'b000_0010,
      ST_STEP  = 7'b000_0100,
      ST_FIND  = 7'b000_1000,
      ST_RND53 = 7'b001_0000,
      ST_RND24 = 7'b010_0000,
      ST_DONE  = 7'b100_0000
   } state_type;

endpackage

FILE: sv/xorshift128_random_source_unit.sv
// xorshift128_random_source_unit: xorshift128 generator with unit-float output
// depends on xrs_pkg for constants and the sequencer state type
`timescale 1ns / 1ps

// Usage
// Request channel (req_): req_tuser selects the kind, 0 = reseed, 1 = draw;
// req_tdata carries the seed word, ignored on a draw. One item is taken
// whenever the sequencer is idle.
// A reseed gives no result and runs 4 multiply steps after it is taken, one
// per state word through the single shared 32x32 multiplier; the next item
// can be taken once the sequencer is back in idle.
// A draw gives one result item on rsp_: the new raw word and the IEEE single
// encoding of raw_word / (2^32 - 1), rounded to double and then to single.
// That quotient is the word repeated as a binary fraction, so one rotator
// finds the leading one and the significand is read from the rotated word:
// a shift-xor step, a search that rotates the word up to its leading one, a
// rounding to double, a rounding to single and a load of the output
// register, which waits while the receiver stalls; the next item can be
// taken once the sequencer is back in idle. A zero word goes straight from
// the shift-xor step to the load.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls, a further draw holds in its last state.
// Reset clears the state words to zero; an unseeded block draws only zeros.

module xorshift128_random_source_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic        req_tuser,   // [0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] raw_word, [63:32] unit_float_bits
);

   localparam int W = xrs_pkg::WORD_W;

   xrs_pkg::state_type state_ff, state_in;

   logic [W-1:0]                gen_ff [xrs_pkg::NUM_WORDS];
   logic [W-1:0]                gen_in [xrs_pkg::NUM_WORDS];
   logic [W-1:0]                w_ff, w_in;
   logic [W-1:0]                raw_ff, raw_in;
   logic [W-1:0]                flt_ff, flt_in;
   logic [xrs_pkg::SIG_W-1:0]   sig_ff, sig_in;
   logic [xrs_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [xrs_pkg::EXP_W-1:0]   exp_ff, exp_in;
   logic                        guard_ff, guard_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [63:0]                 rsp_data_ff, rsp_data_in;

   // shared units
   logic [W-1:0]   mul_src;
   logic [W-1:0]   mul_out;
   logic [W-1:0]   xs_t;
   logic [W-1:0]   xs_w;
   logic           rnd_up;
   logic [xrs_pkg::SGL_W-1:0] sig24;
   logic           out_free;

   // seeding multiplier: one step per cycle, result registered in w_ff
   assign mul_src = w_ff ^ (w_ff >> xrs_pkg::SHIFT_SEED);
   assign mul_out = W'(xrs_pkg::SEED_MULT * mul_src)
                    + W'({cnt_ff[1:0]} + 3'd1);

   // xorshift128 step
   always_comb begin
      xs_t = gen_ff[3];
      xs_t = xs_t ^ (xs_t << xrs_pkg::SHIFT_A);
      xs_t = xs_t ^ (xs_t >> xrs_pkg::SHIFT_B);
      xs_w = xs_t ^ gen_ff[0] ^ (gen_ff[0] >> xrs_pkg::SHIFT_C);
   end

   assign sig24    = sig_ff[xrs_pkg::SIG_W-1 -: xrs_pkg::SGL_W];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      w_in         = w_ff;
      raw_in       = raw_ff;
      flt_in       = flt_ff;
      sig_in       = sig_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      guard_in     = guard_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rnd_up       = 1'b0;

      // result leaves the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         xrs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cnt_in = '0;
               w_in   = req_tdata;
               if (req_tuser == xrs_pkg::REQ_DRAW) begin
                  state_in = xrs_pkg::ST_STEP;
               end else begin
                  state_in = xrs_pkg::ST_SEED;
               end
            end
         end
         xrs_pkg::ST_SEED: begin
            w_in                = mul_out;
            gen_in[cnt_ff[1:0]] = mul_out;
            cnt_in              = cnt_ff + 1'b1;
            if (cnt_ff == xrs_pkg::SEED_LAST) begin
               state_in = xrs_pkg::ST_IDLE;
            end
         end
         xrs_pkg::ST_STEP: begin
            gen_in[3] = gen_ff[2];
            gen_in[2] = gen_ff[1];
            gen_in[1] = gen_ff[0];
            gen_in[0] = xs_w;
            raw_in    = xs_w;
            w_in      = xs_w;
            exp_in    = xrs_pkg::EXP_W'(1);
            if (xs_w == '0) begin
               flt_in   = '0;
               state_in = xrs_pkg::ST_DONE;
            end else begin
               state_in = xrs_pkg::ST_FIND;
            end
         end
         xrs_pkg::ST_FIND: begin
            // rotate up to the leading one; each rotation lowers the exponent
            if (w_ff[W-1]) begin
               // the quotient bits are the rotated word repeated
               sig_in   = {w_ff, w_ff[W-1:W-21]};
               guard_in = w_ff[W-22];
               state_in = xrs_pkg::ST_RND53;
            end else begin
               w_in   = {w_ff[W-2:0], w_ff[W-1]};
               exp_in = exp_ff + 1'b1;
            end
         end
         xrs_pkg::ST_RND53: begin
            // nearest-even to the double significand; the fraction never
            // ends, so the sticky bit is always set
            rnd_up = guard_ff;
            if (rnd_up) begin
               if (&sig_ff) begin
                  sig_in = {1'b1, {(xrs_pkg::SIG_W-1){1'b0}}};
                  exp_in = exp_ff - 1'b1;
               end else begin
                  sig_in = sig_ff + 1'b1;
               end
            end
            state_in = xrs_pkg::ST_RND24;
         end
         xrs_pkg::ST_RND24: begin
            // nearest-even to the single significand
            rnd_up = sig_ff[28] && ((|sig_ff[27:0]) || sig24[0]);
            flt_in = {1'b0, 8'(xrs_pkg::EXP_BIAS - {2'b00, exp_ff}), sig24[22:0]};
            if (rnd_up) begin
               if (&sig24) begin
                  flt_in = {1'b0,
                            8'(xrs_pkg::EXP_BIAS - {2'b00, exp_ff} + 8'd1),
                            23'd0};
               end else begin
                  flt_in[22:0] = 23'(sig24 + 1'b1);
               end
            end
            state_in = xrs_pkg::ST_DONE;
         end
         xrs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {flt_ff, raw_ff};
               state_in     = xrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xrs_pkg::ST_IDLE;
         end
      endcase
   end

   // control and state words
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < xrs_pkg::NUM_WORDS; i++) begin
            gen_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         gen_ff       <= gen_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      raw_ff      <= raw_in;
      flt_ff      <= flt_in;
      sig_ff      <= sig_in;
      exp_ff      <= exp_in;
      guard_ff    <= guard_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == xrs_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a draw goes straight to the shift-xor step
   a_draw_steps: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == xrs_pkg::REQ_DRAW)
      |=> state_ff == xrs_pkg::ST_STEP)
      else $error("draw did not start the xorshift step");

   // a reseed goes to the seeding pass
   a_seed_steps: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == xrs_pkg::REQ_RESEED)
      |=> state_ff == xrs_pkg::ST_SEED)
      else $error("reseed did not start the seeding pass");

   // a zero word encodes as +0.0
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xrs_pkg::ST_DONE) && (raw_ff == '0) |-> flt_ff == '0)
      else $error("zero word did not give +0.0");

   // a full word encodes as 1.0
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xrs_pkg::ST_DONE) && (&raw_ff) |-> flt_ff == xrs_pkg::FLT_ONE)
      else $error("full word did not give 1.0");

endmodule
